FILE: rtl/core/alir_pkg.sv
// Shared types and constants for the array list insert/remove core.
`default_nettype none

package alir_pkg;

  // Fixed field widths of the request and result channels
  localparam int unsigned PosW = 11;
  localparam int unsigned ValW = 16;

  // Default sizing of the list store
  localparam int unsigned CapacityDefault   = 1024;
  localparam int unsigned EntryWidthDefault = 16;

  // Request operation codes
  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  // Result of one request, handed from the sequencer to the output stage
  typedef struct packed {
    logic            ok;
    logic [ValW-1:0] removed_value;
    logic [PosW-1:0] count;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/array_list_insert_remove_core.sv
// Top level of the bounded array list with insert and remove at a position.
//
//   channel  | valid / ready           | payload
//   ---------+-------------------------+-----------------------------------
//   request  | in_valid_i / in_ready_o | func_i, position_i, entry_value_i
//   result   | out_valid_o/out_ready_i | ok_o, removed_value_o, count_o
//
// An insert at position p into a list of n entries shifts entries p to n - 1 up one
// place and then writes the new entry (an append at p = n writes it at once); a remove
// shifts the entries above p down one place; a rejected request only returns a result.
// The sweep moves one entry per cycle through the store's one read and one write port.
// Reset clears the entry count, sequencer state and out_valid_o, not the store contents.
// A finished result waits in the output register; the next item is taken meanwhile,
// but a second finished result holds the sequencer until out_ready_i frees the register.
`default_nettype none

module array_list_insert_remove_core #(
  parameter int unsigned CAPACITY    = alir_pkg::CapacityDefault,
  parameter int unsigned ENTRY_WIDTH = alir_pkg::EntryWidthDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      func_i,
  input  wire logic [alir_pkg::PosW-1:0] position_i,
  input  wire logic [alir_pkg::ValW-1:0] entry_value_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           ok_o,
  output logic      [alir_pkg::ValW-1:0] removed_value_o,
  output logic      [alir_pkg::PosW-1:0] count_o
);

  import alir_pkg::*;

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                   ram_rd_en, ram_wr_en;
  logic [AddrW-1:0]       ram_rd_addr, ram_wr_addr;
  logic [ENTRY_WIDTH-1:0] ram_rd_data, ram_wr_data;
  logic                   res_valid, res_ready;
  res_t                   res;
  logic                   out_valid_q;
  res_t                   out_q;

  alir_ctrl #(
    .Capacity   (CAPACITY),
    .EntryWidth (ENTRY_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .position_i    (position_i),
    .entry_value_i (entry_value_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data)
  );

  alir_ram #(
    .Depth (CAPACITY),
    .Width (ENTRY_WIDTH)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data)
  );

  // Output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = out_q.ok;
  assign removed_value_o = out_q.removed_value;
  assign count_o         = out_q.count;

  // A read and a write never meet at the same entry during a sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_rd_en && ram_wr_en && (ram_rd_addr == ram_wr_addr)))
    else $error("store read and write hit the same entry");

  // Once an item is taken the block is not ready in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while previous one in progress");

  // A rejected request returns no handle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (removed_value_o == '0))
    else $error("rejected request carries a removed handle");

  // The sequencer only offers a result while idle-blocked for requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !in_ready_o)
    else $error("result offered while requests are taken");

endmodule

`default_nettype wire

FILE: rtl/core/alir_ram.sv
// Single-port-read, single-port-write list store with registered read data.
`default_nettype none

module alir_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/alir_ctrl.sv
// Sequencer: checks a request, shifts the list through the store, builds the result.
`default_nettype none

module alir_ctrl #(
  parameter int unsigned Capacity   = alir_pkg::CapacityDefault,
  parameter int unsigned EntryWidth = alir_pkg::EntryWidthDefault,
  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request side
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          func_i,
  input  wire logic [alir_pkg::PosW-1:0]     position_i,
  input  wire logic [alir_pkg::ValW-1:0]     entry_value_i,
  // result side
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output alir_pkg::res_t                     res_o,
  // store access
  output logic                               ram_rd_en_o,
  output logic      [AddrW-1:0]              ram_rd_addr_o,
  input  wire logic [EntryWidth-1:0]         ram_rd_data_i,
  output logic                               ram_wr_en_o,
  output logic      [AddrW-1:0]              ram_wr_addr_o,
  output logic      [EntryWidth-1:0]         ram_wr_data_o
);

  import alir_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned XW   = (EntryWidth > ValW) ? EntryWidth : ValW;

  // Sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StShift = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StWrite = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  pend_q, pend_d;
  logic                  op_q;
  logic [AddrW-1:0]      pos_q;
  logic [EntryWidth-1:0] val_q;
  logic [AddrW-1:0]      ptr_q;
  logic                  pend_head_q;
  logic [AddrW-1:0]      pend_addr_q;
  logic                  ok_q;
  logic [ValW-1:0]       rm_q;

  logic [CmpW-1:0]       pos_ext, cnt_ext;
  logic                  ins_ok, rm_ok, accept, last_rd, pend_wr;
  logic [AddrW-1:0]      pos_addr, cnt_m1;
  logic [XW-1:0]         val_x, rd_x;
  logic [CmpW-1:0]       cnt_out;

  // Request checks against the live count
  assign pos_ext  = CmpW'(position_i);
  assign cnt_ext  = CmpW'(cnt_q);
  assign ins_ok   = (cnt_ext < CmpW'(Capacity)) && (pos_ext <= cnt_ext);
  assign rm_ok    = pos_ext < cnt_ext;
  assign pos_addr = pos_ext[AddrW-1:0];
  assign cnt_m1   = AddrW'(cnt_q - CntW'(1));
  assign accept   = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);

  // Handle width conversions
  assign val_x = XW'(entry_value_i);
  assign rd_x  = XW'(ram_rd_data_i);

  // Last read of the shift sweep
  assign last_rd = (op_q == OpInsert) ? (ptr_q == pos_q) : (ptr_q == cnt_m1);
  // Data from the previous read goes back one place over, unless it is the removed head
  assign pend_wr = pend_q && !pend_head_q;

  // Store port drive
  always_comb begin
    ram_rd_en_o   = 1'b0;
    ram_rd_addr_o = ptr_q;
    ram_wr_en_o   = 1'b0;
    ram_wr_addr_o = pend_addr_q;
    ram_wr_data_o = ram_rd_data_i;
    if (state_q == StShift) begin
      ram_rd_en_o = 1'b1;
    end
    if (pend_wr) begin
      ram_wr_en_o = 1'b1;
    end else if (state_q == StWrite) begin
      ram_wr_en_o   = 1'b1;
      ram_wr_addr_o = pos_q;
      ram_wr_data_o = val_q;
    end
  end

  // Next state and count
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pend_d  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (func_i == OpInsert) begin
            if (!ins_ok) begin
              state_d = StDone;
            end else if (pos_ext == cnt_ext) begin
              state_d = StWrite;
            end else begin
              state_d = StShift;
            end
          end else begin
            state_d = rm_ok ? StShift : StDone;
          end
        end
      end
      StShift: begin
        pend_d = 1'b1;
        if (last_rd) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (op_q == OpInsert) begin
          state_d = StWrite;
        end else begin
          cnt_d   = CntW'(cnt_q - CntW'(1));
          state_d = StDone;
        end
      end
      StWrite: begin
        cnt_d   = CntW'(cnt_q + CntW'(1));
        state_d = StDone;
      end
      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  // Request and sweep payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= func_i;
      pos_q <= pos_addr;
      val_q <= val_x[EntryWidth-1:0];
      ok_q  <= (func_i == OpInsert) ? ins_ok : rm_ok;
      rm_q  <= '0;
      ptr_q <= (func_i == OpInsert) ? cnt_m1 : pos_addr;
    end else if (state_q == StShift) begin
      pend_addr_q <= (op_q == OpInsert) ? AddrW'(ptr_q + AddrW'(1))
                                        : AddrW'(ptr_q - AddrW'(1));
      pend_head_q <= (op_q == OpRemove) && (ptr_q == pos_q);
      ptr_q       <= (op_q == OpInsert) ? AddrW'(ptr_q - AddrW'(1))
                                        : AddrW'(ptr_q + AddrW'(1));
    end
    // Capture the removed handle when its read returns
    if (pend_q && pend_head_q) begin
      rm_q <= rd_x[ValW-1:0];
    end
  end

  // Result
  assign cnt_out             = CmpW'(cnt_q);
  assign res_valid_o         = (state_q == StDone);
  assign res_o.ok            = ok_q;
  assign res_o.removed_value = rm_q;
  assign res_o.count         = cnt_out[PosW-1:0];

endmodule

`default_nettype wire
